### src/split_step_phase_rotator_assert.svh
// Assertion macros shared by the split-step phase rotator RTL.
`ifndef SPLIT_STEP_PHASE_ROTATOR_ASSERT_SVH
`define SPLIT_STEP_PHASE_ROTATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SSPR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sspr assertion failed");

// Next-cycle implication, disabled during reset.
`define SSPR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sspr assertion failed");

`endif

### src/sspr_pkg.sv
// Package of the split-step phase rotator: types, codes and constants.
`timescale 1ns / 1ps
package sspr_pkg;

	localparam int POINTS_DEF = 4096;

	// request codes
	localparam logic [1:0] REQ_KERR      = 2'd0;
	localparam logic [1:0] REQ_NORM_KERR = 2'd1;
	localparam logic [1:0] REQ_DISP      = 2'd2;
	localparam logic [1:0] REQ_PASS      = 2'd3;

	localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
	localparam logic [31:0] PI_Q30  = 32'hC90F_DAA2;

	// Horner steps of the sine and cosine series
	localparam int HSTEPS = 5;
	localparam int SIN_DIV [HSTEPS] = '{110, 72, 42, 20, 6};
	localparam int COS_DIV [HSTEPS] = '{90, 56, 30, 12, 2};

	// sample and request code traveling down the pipe
	typedef struct packed {
		logic [1:0]         mode;
		logic signed [31:0] re;
		logic signed [31:0] im;
	} item_t;

	// context of the trig series
	typedef struct packed {
		item_t       item;
		logic [31:0] x;
		logic [31:0] x2;
		logic [1:0]  quad;
		logic        swap;
	} trig_ctx_t;

endpackage

### src/sspr_phase.sv
// Phase generation: normalize, power or squared index, scale to Q0.32 turns.
`timescale 1ns / 1ps
module sspr_phase import sspr_pkg::*; #(
	parameter int POINTS = POINTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  logic [1:0]         mode,
	input  logic signed [31:0] re,
	input  logic signed [31:0] im,
	input  logic [15:0]        bin,
	input  logic [31:0]        kerr,
	input  logic [47:0]        disp,
	output logic               vld,
	output item_t              item,
	output logic [31:0]        phase
);

	localparam int SH = $clog2(POINTS + 1) - 1;
	localparam logic [32:0] HALF_LSB = 33'(1) << (SH - 1);
	localparam logic [16:0] HALF_PTS = 17'(POINTS / 2);
	localparam logic signed [17:0] PTS = 18'(POINTS);

	logic               vld_s1, vld_s2, vld_s3, vld_s4;
	item_t              item_s1, item_s2, item_s3, item_s4;
	logic signed [17:0] k_s1;
	logic [63:0]        pw_s2;
	logic [32:0]        k2_s2;
	logic [63:0]        ma_s3;
	logic [31:0]        mb_s3;
	logic               k2h_s3;
	logic [31:0]        phase_s4;

	// stage 1: rounded normalize shift and signed frequency index
	logic signed [32:0] re_rnd, im_rnd;
	logic signed [31:0] re_nrm, im_nrm;
	logic signed [17:0] k_c;
	always_comb begin
		re_rnd = $signed({re[31], re}) + $signed(HALF_LSB);
		im_rnd = $signed({im[31], im}) + $signed(HALF_LSB);
		re_nrm = 32'(re_rnd >>> SH);
		im_nrm = 32'(im_rnd >>> SH);
		if ({1'b0, bin} < HALF_PTS) begin
			k_c = $signed({2'b00, bin});
		end else begin
			k_c = $signed({2'b00, bin}) - PTS;
		end
	end

	// stage 2: power and squared index
	logic signed [63:0] sq_re, sq_im;
	logic signed [35:0] kk;
	always_comb begin
		sq_re = item_s1.re * item_s1.re;
		sq_im = item_s1.im * item_s1.im;
		kk    = k_s1 * k_s1;
	end

	// stage 3: split products of turn coefficient and power or index
	logic [31:0] opa1, opa2, opb1, opb2;
	logic [63:0] prod_a, prod_b;
	always_comb begin
		if (item_s2.mode == REQ_DISP) begin
			opa1 = disp[31:0];
			opa2 = k2_s2[31:0];
			opb1 = {16'd0, disp[47:32]};
			opb2 = {16'd0, k2_s2[15:0]};
		end else begin
			opa1 = kerr;
			opa2 = pw_s2[31:0];
			opb1 = kerr;
			opb2 = pw_s2[63:32];
		end
		prod_a = opa1 * opa2;
		prod_b = opb1 * opb2;
	end

	// stage 4: sum partial products, wrap and truncate to Q0.32 turns
	logic [55:0] ksum;
	logic [15:0] dhi;
	logic [47:0] dsum, dneg;
	logic [31:0] phase_c;
	always_comb begin
		ksum = ma_s3[55:0] + {mb_s3[23:0], 32'd0};
		dhi  = mb_s3[15:0] + (k2h_s3 ? disp[15:0] : 16'd0);
		dsum = ma_s3[47:0] + {dhi, 32'd0};
		dneg = 48'd0 - dsum;
		if (item_s3.mode == REQ_DISP) begin
			phase_c = dneg[47:16];
		end else begin
			phase_c = ksum[55:24];
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			item_s1.mode <= mode;
			item_s1.re   <= (mode == REQ_NORM_KERR) ? re_nrm : re;
			item_s1.im   <= (mode == REQ_NORM_KERR) ? im_nrm : im;
			k_s1         <= k_c;
			item_s2      <= item_s1;
			pw_s2        <= 64'(sq_re) + 64'(sq_im);
			k2_s2        <= kk[32:0];
			item_s3      <= item_s2;
			ma_s3        <= prod_a;
			mb_s3        <= prod_b[31:0];
			k2h_s3       <= k2_s2[32];
			item_s4      <= item_s3;
			phase_s4     <= phase_c;
		end
	end

	assign vld   = vld_s4;
	assign item  = item_s4;
	assign phase = phase_s4;

endmodule

### src/sspr_hstep.sv
// One Horner step of the sine and cosine series: t' = 1 - (x2*t)/div.
`timescale 1ns / 1ps
module sspr_hstep import sspr_pkg::*; #(
	parameter int DIV_S = 6,
	parameter int DIV_C = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_vld,
	input  trig_ctx_t   ctx_in,
	input  logic [32:0] ts_in,
	input  logic [32:0] tc_in,
	output logic        vld,
	output trig_ctx_t   ctx,
	output logic [32:0] ts,
	output logic [32:0] tc
);

	// reciprocal constants: quotient estimate is exact or one low
	localparam int SS = 31 + $clog2(DIV_S);
	localparam int SC = 31 + $clog2(DIV_C);
	localparam logic [63:0] MS_W = (64'd1 << SS) / DIV_S;
	localparam logic [63:0] MC_W = (64'd1 << SC) / DIV_C;
	localparam logic [31:0] MS = MS_W[31:0];
	localparam logic [31:0] MC = MC_W[31:0];
	localparam logic [39:0] DS = 40'(DIV_S);
	localparam logic [39:0] DC = 40'(DIV_C);

	logic        vld_s1, vld_s2, vld_s3;
	trig_ctx_t   ctx_s1, ctx_s2, ctx_s3;
	logic [31:0] ys_s1, yc_s1, ys_s2, yc_s2;
	logic [63:0] qs_s2, qc_s2;
	logic [32:0] ts_s3, tc_s3;

	// stage 1: x2 * t, Q0.32
	logic [63:0] ps, pc;
	always_comb begin
		ps = ctx_in.x2 * ts_in[31:0];
		pc = ctx_in.x2 * tc_in[31:0];
	end

	// stage 2: reciprocal multiply
	logic [63:0] rs, rc;
	always_comb begin
		rs = ys_s1 * MS;
		rc = yc_s1 * MC;
	end

	// stage 3: quotient correction and subtract from one
	logic [31:0] es, ec;
	logic [39:0] ds, dc;
	logic [31:0] fs, fc;
	always_comb begin
		es = 32'(qs_s2 >> SS);
		ec = 32'(qc_s2 >> SC);
		ds = {8'd0, ys_s2} - 40'(es) * DS;
		dc = {8'd0, yc_s2} - 40'(ec) * DC;
		fs = (ds >= DS) ? es + 32'd1 : es;
		fc = (dc >= DC) ? ec + 32'd1 : ec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1 <= ctx_in;
			ys_s1  <= ts_in[32] ? ctx_in.x2 : ps[63:32];
			yc_s1  <= tc_in[32] ? ctx_in.x2 : pc[63:32];
			ctx_s2 <= ctx_s1;
			ys_s2  <= ys_s1;
			yc_s2  <= yc_s1;
			qs_s2  <= rs;
			qc_s2  <= rc;
			ctx_s3 <= ctx_s2;
			ts_s3  <= ONE_Q32 - {1'b0, fs};
			tc_s3  <= ONE_Q32 - {1'b0, fc};
		end
	end

	assign vld = vld_s3;
	assign ctx = ctx_s3;
	assign ts  = ts_s3;
	assign tc  = tc_s3;

endmodule

### src/sspr_trig.sv
// Phase to cosine and sine in Q1.30: fold, series steps, quadrant map.
`timescale 1ns / 1ps
module sspr_trig import sspr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  item_t              item_in,
	input  logic [31:0]        phase,
	output logic               vld,
	output item_t              item,
	output logic signed [31:0] cos_v,
	output logic signed [31:0] sin_v
);

	localparam logic [1:0] QUAD_I   = 2'd0;
	localparam logic [1:0] QUAD_II  = 2'd1;
	localparam logic [1:0] QUAD_III = 2'd2;
	localparam logic [1:0] QUAD_IV  = 2'd3;

	logic        vld_s1, vld_s2;
	item_t       item_s1, item_s2;
	logic [1:0]  quad_s1, quad_s2;
	logic        swap_s1, swap_s2;
	logic [61:0] prod_s1;
	logic [31:0] x_s2;
	logic [63:0] xx_s2;

	// stage 1: fold to [0, pi/4] and scale by pi
	logic [30:0] v;
	logic [62:0] pv;
	always_comb begin
		v = phase[29] ? (31'h4000_0000 - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
		pv = v * PI_Q30;
	end

	// stage 2: x and x squared
	logic [31:0] x_c;
	logic [63:0] xx_c;
	always_comb begin
		x_c  = prod_s1[60:29];
		xx_c = x_c * x_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= item_in;
			quad_s1 <= phase[31:30];
			swap_s1 <= phase[29];
			prod_s1 <= pv[61:0];
			item_s2 <= item_s1;
			quad_s2 <= quad_s1;
			swap_s2 <= swap_s1;
			x_s2    <= x_c;
			xx_s2   <= xx_c;
		end
	end

	// Horner chain, both series side by side
	trig_ctx_t   ctx_h [HSTEPS+1];
	logic [32:0] ts_h  [HSTEPS+1];
	logic [32:0] tc_h  [HSTEPS+1];
	logic        vld_h [HSTEPS+1];

	assign ctx_h[0] = {item_s2, x_s2, xx_s2[63:32], quad_s2, swap_s2};
	assign ts_h[0]  = ONE_Q32;
	assign tc_h[0]  = ONE_Q32;
	assign vld_h[0] = vld_s2;

	for (genvar g = 0; g < HSTEPS; g++) begin : g_step
		sspr_hstep #(
			.DIV_S(SIN_DIV[g]),
			.DIV_C(COS_DIV[g])
		) u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.in_vld (vld_h[g]),
			.ctx_in (ctx_h[g]),
			.ts_in  (ts_h[g]),
			.tc_in  (tc_h[g]),
			.vld    (vld_h[g+1]),
			.ctx    (ctx_h[g+1]),
			.ts     (ts_h[g+1]),
			.tc     (tc_h[g+1])
		);
	end

	logic        vld_s3, vld_s4;
	trig_ctx_t   ctx_s3;
	logic [31:0] sp_s3;
	logic [32:0] cp_s3;
	item_t       item_s4;
	logic signed [31:0] cos_s4, sin_s4;

	// stage 3: last sine multiply by x
	logic [63:0] xs;
	always_comb begin
		xs = ctx_h[HSTEPS].x * ts_h[HSTEPS][31:0];
	end

	// stage 4: undo fold, round to Q1.30, map quadrant
	logic [32:0] sv, cv;
	logic [33:0] sr, cr;
	logic signed [31:0] sn, cs;
	logic signed [31:0] cos_c, sin_c;
	always_comb begin
		sv = ctx_s3.swap ? cp_s3 : {1'b0, sp_s3};
		cv = ctx_s3.swap ? {1'b0, sp_s3} : cp_s3;
		sr = {1'b0, sv} + 34'd2;
		cr = {1'b0, cv} + 34'd2;
		sn = $signed({1'b0, sr[32:2]});
		cs = $signed({1'b0, cr[32:2]});
		case (ctx_s3.quad)
			QUAD_I: begin
				cos_c = cs;
				sin_c = sn;
			end
			QUAD_II: begin
				cos_c = -sn;
				sin_c = cs;
			end
			QUAD_III: begin
				cos_c = -cs;
				sin_c = -sn;
			end
			QUAD_IV: begin
				cos_c = sn;
				sin_c = -cs;
			end
			default: begin
				cos_c = cs;
				sin_c = sn;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_h[HSTEPS];
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s3  <= ctx_h[HSTEPS];
			sp_s3   <= ts_h[HSTEPS][32] ? ctx_h[HSTEPS].x : xs[63:32];
			cp_s3   <= tc_h[HSTEPS];
			item_s4 <= ctx_s3.item;
			cos_s4  <= cos_c;
			sin_s4  <= sin_c;
		end
	end

	assign vld   = vld_s4;
	assign item  = item_s4;
	assign cos_v = cos_s4;
	assign sin_v = sin_s4;

endmodule

### src/sspr_rotate.sv
// Complex rotation by cosine and sine, rounding and saturation.
`timescale 1ns / 1ps
module sspr_rotate import sspr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  item_t              item_in,
	input  logic signed [31:0] cos_v,
	input  logic signed [31:0] sin_v,
	output logic               vld,
	output logic signed [31:0] re,
	output logic signed [31:0] im,
	output logic               clip
);

	localparam logic signed [34:0] MAX32 = 35'sh0_7FFF_FFFF;
	localparam logic signed [34:0] MIN32 = -35'sh0_8000_0000;
	localparam logic signed [64:0] HALF_R = 65'sh2000_0000;

	logic               vld_s1, vld_s2, vld_s3;
	item_t              item_s1, item_s2;
	logic signed [63:0] pa_s1, pb_s1, pc_s1, pd_s1;
	logic signed [34:0] rre_s2, rim_s2;
	logic signed [31:0] re_s3, im_s3;
	logic               clip_s3;

	// stage 1: four partial products
	logic signed [63:0] pa, pb, pc, pd;
	always_comb begin
		pa = item_in.re * cos_v;
		pb = item_in.im * sin_v;
		pc = item_in.re * sin_v;
		pd = item_in.im * cos_v;
	end

	// stage 2: combine and round half up to Q16.16
	logic signed [64:0] acc_re, acc_im, rnd_re, rnd_im;
	always_comb begin
		acc_re = 65'(pa_s1) - 65'(pb_s1);
		acc_im = 65'(pc_s1) + 65'(pd_s1);
		rnd_re = (acc_re + HALF_R) >>> 30;
		rnd_im = (acc_im + HALF_R) >>> 30;
	end

	// stage 3: saturate, pass-through code keeps the sample
	logic signed [31:0] re_c, im_c;
	logic               clip_c;
	always_comb begin
		clip_c = 1'b0;
		if (rre_s2 > MAX32) begin
			re_c = 32'sh7FFF_FFFF;
			clip_c = 1'b1;
		end else if (rre_s2 < MIN32) begin
			re_c = 32'sh8000_0000;
			clip_c = 1'b1;
		end else begin
			re_c = 32'(rre_s2);
		end
		if (rim_s2 > MAX32) begin
			im_c = 32'sh7FFF_FFFF;
			clip_c = 1'b1;
		end else if (rim_s2 < MIN32) begin
			im_c = 32'sh8000_0000;
			clip_c = 1'b1;
		end else begin
			im_c = 32'(rim_s2);
		end
		if (item_s2.mode == REQ_PASS) begin
			re_c = item_s2.re;
			im_c = item_s2.im;
			clip_c = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= item_in;
			pa_s1   <= pa;
			pb_s1   <= pb;
			pc_s1   <= pc;
			pd_s1   <= pd;
			item_s2 <= item_s1;
			rre_s2  <= 35'(rnd_re);
			rim_s2  <= 35'(rnd_im);
			re_s3   <= re_c;
			im_s3   <= im_c;
			clip_s3 <= clip_c;
		end
	end

	assign vld  = vld_s3;
	assign re   = re_s3;
	assign im   = im_s3;
	assign clip = clip_s3;

endmodule

### src/split_step_phase_rotator.sv
// Top level of the split-step phase rotator: config port and pipeline.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one word per cycle while
//   in_stall is low: request code, complex Q16.16 sample and bin number.
//   Output channel (out_valid / out_stall) returns one word per input
//   word, in order: rotated sample and the saturation flag.
//   The pipeline has 4 phase stages, 19 trig stages (fold, square, five
//   three-stage Horner steps, final multiply, quadrant map) and 3
//   rotation stages. Throughput is one word per cycle while out_stall
//   does not hold the pipeline.
//   The APB port holds kerr_turns at 0x0 and disp_turns at 0x8; write it
//   only while the pipeline is empty. pready is always high.
//   Reset clears both coefficients and all valid bits; no words remain.
//   When the receiver stalls a valid word, the whole pipeline holds;
//   in_stall rises in the same cycle so nothing is dropped or repeated,
//   and the held result stays on the output ports.
`timescale 1ns / 1ps
`include "split_step_phase_rotator_assert.svh"
module split_step_phase_rotator import sspr_pkg::*; #(
	parameter int POINTS = POINTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         req_type,
	input  logic signed [31:0] sample_re,
	input  logic signed [31:0] sample_im,
	input  logic [15:0]        bin_index,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] out_re,
	output logic signed [31:0] out_im,
	output logic               clipped
);

	logic [31:0] kerr_q;
	logic [47:0] disp_q;
	logic        cfg_wr;

	// config registers
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kerr_q <= 32'd0;
			disp_q <= 48'd0;
		end else if (cfg_wr) begin
			if (paddr[3]) begin
				disp_q <= pwdata[47:0];
			end else begin
				kerr_q <= pwdata[31:0];
			end
		end
	end
	assign prdata = paddr[3] ? {16'd0, disp_q} : {32'd0, kerr_q};

	// global pipeline advance
	logic en;
	assign en       = ~(out_valid & out_stall);
	assign in_stall = ~en;

	logic               ph_vld, tr_vld;
	item_t              ph_item, tr_item;
	logic [31:0]        ph_phase;
	logic signed [31:0] tr_cos, tr_sin;

	sspr_phase #(.POINTS(POINTS)) u_phase (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (in_valid),
		.mode   (req_type),
		.re     (sample_re),
		.im     (sample_im),
		.bin    (bin_index),
		.kerr   (kerr_q),
		.disp   (disp_q),
		.vld    (ph_vld),
		.item   (ph_item),
		.phase  (ph_phase)
	);

	sspr_trig u_trig (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (ph_vld),
		.item_in (ph_item),
		.phase   (ph_phase),
		.vld     (tr_vld),
		.item    (tr_item),
		.cos_v   (tr_cos),
		.sin_v   (tr_sin)
	);

	sspr_rotate u_rotate (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (tr_vld),
		.item_in (tr_item),
		.cos_v   (tr_cos),
		.sin_v   (tr_sin),
		.vld     (out_valid),
		.re      (out_re),
		.im      (out_im),
		.clip    (clipped)
	);

	// a flagged word has at least one part at a rail
	`SSPR_ASSERT_IMP(a_clip_rail, clk, arst_n, out_valid && clipped,
		out_re == 32'sh7FFF_FFFF || out_re == 32'sh8000_0000 ||
		out_im == 32'sh7FFF_FFFF || out_im == 32'sh8000_0000)
	// input is held back only by a blocked output
	`SSPR_ASSERT_IMP(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall)
	// a kerr write lands in the register
	`SSPR_ASSERT_NXT(a_kerr_wr, clk, arst_n, psel && penable && pwrite && !paddr[3],
		kerr_q == $past(pwdata[31:0]))

endmodule
